FILE: rtl/core/gpfa_pkg.sv
package gpfa_pkg;

  localparam int Particles = 1024;
  localparam int IdxW = $clog2(Particles);
  localparam int InIdxW = 10;

  typedef enum logic [1:0] {
    ACT_BOTH  = 2'd0,
    ACT_I     = 2'd1,
    ACT_RET   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [9:0] index_i;
    logic [9:0] index_j;
    logic signed [31:0] pos_i_x;
    logic signed [31:0] pos_i_y;
    logic signed [31:0] pos_i_z;
    logic [31:0] mass_i;
    logic signed [31:0] pos_j_x;
    logic signed [31:0] pos_j_y;
    logic signed [31:0] pos_j_z;
    logic [31:0] mass_j;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic signed [63:0] force_z;
    logic singular;
  } out_item_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add = s[63:0];
  endfunction

  function automatic logic signed [63:0] neg_sat(input logic signed [63:0] a);
    if (a == {1'b1, 63'd0}) neg_sat = {1'b0, {63{1'b1}}};
    else neg_sat = -a;
  endfunction

endpackage

FILE: rtl/core/gpfa_if.sv
interface gpfa_in_if;
  logic valid;
  logic ready;
  gpfa_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gpfa_out_if;
  logic valid;
  logic ready;
  gpfa_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/gravity_pair_force_accumulator.sv
// a force item, whether returned only or also added to the store, runs five
// 96-step serial divisions in the shared divider; read-and-clear and
// zero-distance items run none
// one item at a time; the next is accepted once the result beat leaves
// reset: synchronous active-low rst_n, then a clearing pass over all 1024
// force store entries, during which no item is accepted
module gravity_pair_force_accumulator (
  input logic      clk,
  input logic      rst_n,
  gpfa_in_if.sink  in_ch,
  gpfa_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FORCE, S_RD_I, S_WB_I, S_RD_J, S_WB_J, S_RD_C, S_WB_C, S_OUT
  } state_t;

  state_t state_r;
  gpfa_pkg::in_item_t item_r;
  gpfa_pkg::vec_t f_r, rdata, wdata;
  logic sing_r;
  logic [gpfa_pkg::IdxW:0] clr_r;
  logic we;
  logic [gpfa_pkg::IdxW-1:0] waddr, raddr;
  logic f_start, f_done, f_sing;
  gpfa_pkg::vec_t f_out;
  logic i_ok, j_ok;

  assign i_ok = 32'(item_r.index_i) < 32'(gpfa_pkg::Particles);
  assign j_ok = 32'(item_r.index_j) < 32'(gpfa_pkg::Particles);

  gpfa_force u_force (
    .clk(clk), .rst_n(rst_n), .start(f_start), .item(item_r),
    .done(f_done), .force_o(f_out), .singular(f_sing)
  );

  gpfa_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = {f_r.x, f_r.y, f_r.z, sing_r};

  always_comb begin
    we = 1'b0;
    waddr = gpfa_pkg::IdxW'(item_r.index_i);
    wdata = '0;
    raddr = gpfa_pkg::IdxW'(item_r.index_i);
    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_r[gpfa_pkg::IdxW-1:0];
      end
      S_RD_J, S_WB_J: raddr = gpfa_pkg::IdxW'(item_r.index_j);
      default: ;
    endcase
    unique case (state_r)
      S_WB_I: begin
        we = i_ok;
        wdata.x = gpfa_pkg::sat_add(rdata.x, f_r.x);
        wdata.y = gpfa_pkg::sat_add(rdata.y, f_r.y);
        wdata.z = gpfa_pkg::sat_add(rdata.z, f_r.z);
      end
      S_WB_J: begin
        we = j_ok;
        waddr = gpfa_pkg::IdxW'(item_r.index_j);
        wdata.x = gpfa_pkg::sat_add(rdata.x, gpfa_pkg::neg_sat(f_r.x));
        wdata.y = gpfa_pkg::sat_add(rdata.y, gpfa_pkg::neg_sat(f_r.y));
        wdata.z = gpfa_pkg::sat_add(rdata.z, gpfa_pkg::neg_sat(f_r.z));
      end
      S_WB_C: we = i_ok;
      default: ;
    endcase
  end

  assign f_start = (state_r == S_FORCE) && !f_done && (clr_r[0] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (gpfa_pkg::IdxW+1)'(gpfa_pkg::Particles - 1)) begin
            state_r <= S_IDLE;
            clr_r <= '0;
          end
        end
        S_IDLE: if (in_ch.valid) begin
          item_r <= in_ch.data;
          clr_r <= '0;
          state_r <= (in_ch.data.action == gpfa_pkg::ACT_CLEAR) ? S_RD_C : S_FORCE;
        end
        S_FORCE: begin
          clr_r[0] <= 1'b1;
          if (f_done) begin
            f_r <= f_out;
            sing_r <= f_sing;
            if (f_sing || item_r.action == gpfa_pkg::ACT_RET) state_r <= S_OUT;
            else state_r <= S_RD_I;
          end
        end
        S_RD_I: state_r <= S_WB_I;
        S_WB_I: state_r <= (item_r.action == gpfa_pkg::ACT_BOTH) ? S_RD_J : S_OUT;
        S_RD_J: state_r <= S_WB_J;
        S_WB_J: state_r <= S_OUT;
        S_RD_C: state_r <= S_WB_C;
        S_WB_C: begin
          f_r <= i_ok ? rdata : '0;
          sing_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready during result");
  a_clear_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB_C) |=> !sing_r) else $error("flag on read-and-clear");
  a_out_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB_J) |=> out_ch.valid) else $error("missing result");
`endif

endmodule

FILE: rtl/core/gpfa_divider.sv
module gpfa_divider (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [95:0]  num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [95:0]  quo
);

  logic [95:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [64:0] sh;

  always_comb begin
    sh = {rem_r[63:0], q_r[95]};
    q_nxt = {q_r[94:0], 1'b0};
    rem_nxt = sh;
    if (sh >= {1'b0, den_r}) begin
      rem_nxt = sh - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd0;
        q_r <= num;
        rem_r <= '0;
        den_r <= den;
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd95) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q_r;

endmodule

FILE: rtl/core/gpfa_force.sv
module gpfa_force (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gpfa_pkg::in_item_t  item,
  output logic                done,
  output gpfa_pkg::vec_t      force_o,
  output logic                singular
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQ, S_SQRT, S_T, S_G, S_U, S_MUL1, S_MAG, S_DONE
  } state_t;

  state_t state_r;
  logic signed [32:0] d_r [3];
  logic [32:0] a_r [3];
  logic [31:0] n_r [3];
  logic signed [6:0] s_r;
  logic [63:0] m_r, sq_r, r_r, bit_r, v_r, g_r, p_r;
  logic [127:0] mp_r;
  logic [1:0] ax_r;
  logic [1:0] mc_r;
  logic [63:0] mag_r [3];
  logic start_div;
  logic [95:0] div_num, div_q;
  logic div_done;
  logic [32:0] big;
  logic [5:0] msb;
  logic [127:0] shv;
  logic [6:0] sh;
  logic [63:0] mag;
  logic [32:0] tmp_a [3];
  logic signed [32:0] tmp_d [3];
  logic [31:0] pm_a, pm_b;
  logic [63:0] pp;
  logic [127:0] pp_sh;

  gpfa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(start_div), .num(div_num), .den(r_r),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    tmp_d[0] = {item.pos_i_x[31], item.pos_i_x} - {item.pos_j_x[31], item.pos_j_x};
    tmp_d[1] = {item.pos_i_y[31], item.pos_i_y} - {item.pos_j_y[31], item.pos_j_y};
    tmp_d[2] = {item.pos_i_z[31], item.pos_i_z} - {item.pos_j_z[31], item.pos_j_z};
    for (int k = 0; k < 3; k++) tmp_a[k] = tmp_d[k][32] ? -tmp_d[k] : tmp_d[k];
    big = a_r[0] | a_r[1] | a_r[2];
    msb = '0;
    for (int b = 0; b < 33; b++) if (big[b]) msb = 6'(b);
    sh = 7'(7'd91 - 7'(2 * s_r));
    shv = mp_r >> sh;
    mag = (shv[127:63] != '0) ? {1'b0, {63{1'b1}}} : shv[63:0];
    // one 32x32 partial product per cycle
    pm_a = mc_r[0] ? m_r[63:32] : m_r[31:0];
    pm_b = mc_r[1] ? p_r[63:32] : p_r[31:0];
    pp = 64'(pm_a) * 64'(pm_b);
    pp_sh = 128'(pp) << {2'(mc_r[0]) + 2'(mc_r[1]), 5'd0};
  end

  always_comb begin
    start_div = 1'b0;
    div_num = '0;
    unique case (state_r)
      S_SQRT: if (bit_r == '0) begin
        start_div = 1'b1;
        div_num = {32'd0, 1'b1, 63'd0};
      end
      S_T: if (div_done) begin
        start_div = 1'b1;
        div_num = {div_q[65:0], 30'd0};
      end
      S_G: if (div_done) begin
        start_div = 1'b1;
        div_num = {34'd0, n_r[0], 30'd0};
      end
      S_MAG: if (ax_r != 2'd2) begin
        start_div = 1'b1;
        div_num = {34'd0, n_r[ax_r + 2'd1], 30'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          for (int k = 0; k < 3; k++) begin
            d_r[k] <= tmp_d[k];
            a_r[k] <= tmp_a[k];
          end
          m_r <= 64'(item.mass_i) * 64'(item.mass_j);
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (big == '0) begin
            singular <= 1'b1;
            force_o <= '0;
            done <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            s_r <= 7'(7'sd30 - 7'(msb));
            for (int k = 0; k < 3; k++)
              n_r[k] <= (msb <= 6'd30) ? 32'(a_r[k] << (6'd30 - msb))
                                       : 32'(a_r[k] >> (msb - 6'd30));
            ax_r <= 2'd0;
            sq_r <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= sq_r + 64'(n_r[ax_r]) * 64'(n_r[ax_r]);
          if (ax_r == 2'd2) begin
            bit_r <= 64'd1 << 62;
            r_r <= '0;
            state_r <= S_SQRT;
            v_r <= sq_r + 64'(n_r[ax_r]) * 64'(n_r[ax_r]);
          end
          ax_r <= ax_r + 2'd1;
        end
        S_SQRT: begin
          if (bit_r != '0) begin
            if (v_r >= r_r + bit_r) begin
              v_r <= v_r - (r_r + bit_r);
              r_r <= (r_r >> 1) + bit_r;
            end else begin
              r_r <= r_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            state_r <= S_T;
          end
        end
        S_T: if (div_done) begin
          state_r <= S_G;
        end
        S_G: if (div_done) begin
          g_r <= div_q[63:0];
          ax_r <= 2'd0;
          state_r <= S_U;
        end
        S_U: if (div_done) begin
          p_r <= 64'(div_q[30:0]) * 64'(g_r[33:0]);
          mp_r <= '0;
          mc_r <= 2'd0;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          mp_r <= mp_r + pp_sh;
          mc_r <= mc_r + 2'd1;
          if (mc_r == 2'd3) state_r <= S_MAG;
        end
        S_MAG: begin
          mag_r[ax_r] <= mag;
          if (ax_r == 2'd2) state_r <= S_DONE;
          else begin
            ax_r <= ax_r + 2'd1;
            state_r <= S_U;
          end
        end
        S_DONE: begin
          force_o.x <= d_r[0] > 0 ? -mag_r[0] : mag_r[0];
          force_o.y <= d_r[1] > 0 ? -mag_r[1] : mag_r[1];
          force_o.z <= d_r[2] > 0 ? -mag_r[2] : mag_r[2];
          singular <= 1'b0;
          done <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/gpfa_store.sv
module gpfa_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [gpfa_pkg::IdxW-1:0]       waddr,
  input  gpfa_pkg::vec_t                  wdata,
  input  logic [gpfa_pkg::IdxW-1:0]       raddr,
  output gpfa_pkg::vec_t                  rdata
);

  gpfa_pkg::vec_t mem [gpfa_pkg::Particles];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
